/* rtl/core/pucrp_pkg.sv */
// Shared types and constants for the picture unit processor register port.
package pucrp_pkg;

    localparam int unsigned DEF_VIDEO_MEM_DEPTH = 16384;
    localparam int unsigned ADDR_W              = 15;
    localparam int unsigned DATA_W              = 8;
    localparam int unsigned FLAGS_W             = 7;
    localparam int unsigned FINE_W              = 3;

    localparam logic [ADDR_W-1:0] STEP_ROW  = 15'd32;
    localparam logic [ADDR_W-1:0] STEP_BYTE = 15'd1;

    typedef enum logic [2:0] {
        ACT_CTRL     = 3'd0,
        ACT_STATUS   = 3'd1,
        ACT_SCROLL   = 3'd2,
        ACT_ADDR     = 3'd3,
        ACT_WDATA    = 3'd4,
        ACT_RDATA    = 3'd5,
        ACT_VB_START = 3'd6,
        ACT_VB_END   = 3'd7
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [DATA_W-1:0]    data_byte;
        logic [FLAGS_W-1:0]   status_flags;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]    read_data;
        logic                 nmi_request;
        logic [ADDR_W-1:0]    current_address;
        logic [ADDR_W-1:0]    temporary_address;
        logic [FINE_W-1:0]    fine_scroll_x;
    } t_out_item;

endpackage

/* rtl/core/picture_unit_cpu_register_port.sv */
// Top level of the picture unit processor register port.
//
// Accepts one transaction per clock cycle, back to back, while i_out_ready stays high, and
// returns one result per transaction, registered first by the synchronous read of the
// video memory and then by the output register. Scroll, address and flag registers update
// at acceptance, so each transaction sees the effect of the one before it. The video
// memory is a single-port RAM addressed by current address bits 13..0, mirrored to
// VIDEO_MEM_DEPTH entries; its contents are undefined until written. Data reads return
// the addressed byte directly, with no read buffer, and then step the current address.
module picture_unit_cpu_register_port #(
    parameter int unsigned VIDEO_MEM_DEPTH = pucrp_pkg::DEF_VIDEO_MEM_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pucrp_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pucrp_pkg::t_out_item o_out_item
);

    localparam int unsigned MEM_AW = $clog2(VIDEO_MEM_DEPTH);
    localparam logic [16:0] DEPTH_X1 = 17'(VIDEO_MEM_DEPTH);
    localparam logic [16:0] DEPTH_X2 = 17'(2 * VIDEO_MEM_DEPTH);
    localparam logic [16:0] DEPTH_X4 = 17'(4 * VIDEO_MEM_DEPTH);

    logic [pucrp_pkg::ADDR_W-1:0] r_cur_addr,     n_cur_addr;
    logic [pucrp_pkg::ADDR_W-1:0] r_tmp_addr,     n_tmp_addr;
    logic [pucrp_pkg::FINE_W-1:0] r_fine_x,       n_fine_x;
    logic                         r_write_toggle, n_write_toggle;
    logic                         r_nmi_enable,   n_nmi_enable;
    logic                         r_vblank,       n_vblank;
    logic                         r_step_by_row,  n_step_by_row;

    logic                         r_s1_valid;
    logic                         r_s1_mem;
    pucrp_pkg::t_out_item         r_s1_item;
    logic                         r_out_valid;
    pucrp_pkg::t_out_item         r_out_item;

    logic                         w_accept;
    logic                         w_s1_move;
    logic [pucrp_pkg::DATA_W-1:0] w_status_rd;
    logic                         w_mem_en;
    logic                         w_mem_we;
    logic                         w_mem_rd;
    logic [16:0]                  w_red0, w_red1, w_red2, w_red3;
    logic [MEM_AW-1:0]            w_mem_addr;
    logic [pucrp_pkg::DATA_W-1:0] w_mem_rdata;
    logic [pucrp_pkg::ADDR_W-1:0] w_stepped;
    pucrp_pkg::t_out_item         w_s1_item;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_move;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_stepped = r_cur_addr + (r_step_by_row ? pucrp_pkg::STEP_ROW
                                                   : pucrp_pkg::STEP_BYTE);

    // mirror bits 13..0 onto the memory depth by conditional subtraction
    assign w_red0     = {3'b000, r_cur_addr[13:0]};
    assign w_red1     = (w_red0 >= DEPTH_X4) ? w_red0 - DEPTH_X4 : w_red0;
    assign w_red2     = (w_red1 >= DEPTH_X2) ? w_red1 - DEPTH_X2 : w_red1;
    assign w_red3     = (w_red2 >= DEPTH_X1) ? w_red2 - DEPTH_X1 : w_red2;
    assign w_mem_addr = w_red3[MEM_AW-1:0];

    always_comb begin
        n_cur_addr     = r_cur_addr;
        n_tmp_addr     = r_tmp_addr;
        n_fine_x       = r_fine_x;
        n_write_toggle = r_write_toggle;
        n_nmi_enable   = r_nmi_enable;
        n_vblank       = r_vblank;
        n_step_by_row  = r_step_by_row;
        w_status_rd    = '0;
        w_mem_we       = 1'b0;
        w_mem_rd       = 1'b0;
        unique case (i_in_item.action)
            pucrp_pkg::ACT_CTRL: begin
                n_tmp_addr[11:10] = i_in_item.data_byte[1:0];
                n_step_by_row     = i_in_item.data_byte[2];
                n_nmi_enable      = i_in_item.data_byte[7];
            end
            pucrp_pkg::ACT_STATUS: begin
                w_status_rd    = {r_vblank, i_in_item.status_flags};
                n_vblank       = 1'b0;
                n_write_toggle = 1'b0;
            end
            pucrp_pkg::ACT_SCROLL: begin
                if (!r_write_toggle) begin
                    n_tmp_addr[4:0] = i_in_item.data_byte[7:3];
                    n_fine_x        = i_in_item.data_byte[2:0];
                    n_write_toggle  = 1'b1;
                end else begin
                    n_tmp_addr[14:12] = i_in_item.data_byte[2:0];
                    n_tmp_addr[9:5]   = i_in_item.data_byte[7:3];
                    n_write_toggle    = 1'b0;
                end
            end
            pucrp_pkg::ACT_ADDR: begin
                if (!r_write_toggle) begin
                    n_tmp_addr[14]   = 1'b0;
                    n_tmp_addr[13:8] = i_in_item.data_byte[5:0];
                    n_write_toggle   = 1'b1;
                end else begin
                    n_tmp_addr[7:0] = i_in_item.data_byte;
                    n_cur_addr      = {r_tmp_addr[14:8], i_in_item.data_byte};
                    n_write_toggle  = 1'b0;
                end
            end
            pucrp_pkg::ACT_WDATA: begin
                w_mem_we   = 1'b1;
                n_cur_addr = w_stepped;
            end
            pucrp_pkg::ACT_RDATA: begin
                w_mem_rd   = 1'b1;
                n_cur_addr = w_stepped;
            end
            pucrp_pkg::ACT_VB_START: begin
                n_vblank = 1'b1;
            end
            pucrp_pkg::ACT_VB_END: begin
                n_vblank = 1'b0;
            end
            default: begin
                n_vblank = r_vblank;
            end
        endcase
    end

    assign w_mem_en = w_accept && (w_mem_we || w_mem_rd);

    pucrp_ram #(
        .WIDTH (pucrp_pkg::DATA_W),
        .DEPTH (VIDEO_MEM_DEPTH)
    ) u_video_mem (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (i_in_item.data_byte),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_addr     <= '0;
            r_tmp_addr     <= '0;
            r_fine_x       <= '0;
            r_write_toggle <= 1'b0;
            r_nmi_enable   <= 1'b0;
            r_vblank       <= 1'b0;
            r_step_by_row  <= 1'b0;
        end else if (w_accept) begin
            r_cur_addr     <= n_cur_addr;
            r_tmp_addr     <= n_tmp_addr;
            r_fine_x       <= n_fine_x;
            r_write_toggle <= n_write_toggle;
            r_nmi_enable   <= n_nmi_enable;
            r_vblank       <= n_vblank;
            r_step_by_row  <= n_step_by_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_mem                    <= w_mem_rd;
            r_s1_item.read_data         <= w_status_rd;
            r_s1_item.nmi_request       <= n_nmi_enable & n_vblank;
            r_s1_item.current_address   <= n_cur_addr;
            r_s1_item.temporary_address <= n_tmp_addr;
            r_s1_item.fine_scroll_x     <= n_fine_x;
        end
        if (w_s1_move) begin
            r_out_item <= w_s1_item;
        end
    end

    always_comb begin
        w_s1_item = r_s1_item;
        if (r_s1_mem) begin
            w_s1_item.read_data = w_mem_rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* rtl/core/pucrp_ram.sv */
// Single-port synchronous RAM with registered read data.
module pucrp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
